>>> design/spq_pkg.sv
// Shared types and constants for the sorted priority queue.
package spq_pkg;

    localparam int SPQ_DEPTH     = 16;
    localparam int SPQ_KEY_WIDTH = 16;

    localparam int IN_KEY_W   = 16;
    localparam int FRONT_W    = 16;
    localparam int ECOUNT_W   = 5;
    localparam int STATUS_W   = 2;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 24;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_UNDERFLOW = 2'd1;
    localparam logic [STATUS_W-1:0] ST_OVERFLOW  = 2'd2;

    typedef enum logic [0:0] {
        S_IDLE,
        S_EXEC
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic capture;
        logic execute;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic out_free;
    } t_dp_stat;

endpackage

>>> design/spq_ctrl.sv
// Sequencer: takes a command, then runs it once the result register is free.
module spq_ctrl
    import spq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (i_stat.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_in_ready    = 1'b0;
        o_cmd.capture = 1'b0;
        o_cmd.execute = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.capture = i_in_valid;
            end
            S_EXEC: begin
                o_cmd.execute = i_stat.out_free;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> design/spq_datapath.sv
// Row of compare-and-shift key cells, count register and result register.
module spq_datapath
    import spq_pkg::*;
#(
    parameter int DEPTH     = SPQ_DEPTH,
    parameter int KEY_WIDTH = SPQ_KEY_WIDTH
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    output t_dp_stat            o_stat,
    input  logic                i_command,
    input  logic [IN_KEY_W-1:0] i_key,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [FRONT_W-1:0]  o_front_key,
    output logic [ECOUNT_W-1:0] o_entry_count,
    output logic                o_empty_flag,
    output logic                o_full_flag,
    output logic [STATUS_W-1:0] o_status
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                 r_cmd;
    logic [KEY_WIDTH-1:0] r_key;
    logic [CNT_W-1:0]     r_count;
    logic [CNT_W-1:0]     n_count;
    logic [KEY_WIDTH-1:0] r_keys [DEPTH];
    logic [KEY_WIDTH-1:0] n_keys [DEPTH];

    logic [DEPTH-1:0]     w_valid;
    logic [DEPTH-1:0]     w_gt;
    logic [DEPTH-1:0]     w_prev_gt;
    logic [KEY_WIDTH-1:0] w_prev_key [DEPTH];
    logic [KEY_WIDTH-1:0] w_next_key [DEPTH];

    logic                 w_full;
    logic                 w_empty;
    logic                 w_do_ins;
    logic                 w_do_rem;
    logic [STATUS_W-1:0]  n_status;
    logic [FRONT_W-1:0]   n_front;

    logic                 r_out_valid;
    logic [FRONT_W-1:0]   r_front;
    logic [ECOUNT_W-1:0]  r_ecount;
    logic                 r_empty;
    logic                 r_full;
    logic [STATUS_W-1:0]  r_status;

    // per-cell compare and neighbor wiring
    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        assign w_valid[g] = (CNT_W'(g) < r_count);
        assign w_gt[g]    = w_valid[g] && (r_keys[g] > r_key);
        if (g == 0) begin : g_first
            assign w_prev_gt[g]  = 1'b0;
            assign w_prev_key[g] = r_key;
        end else begin : g_mid
            assign w_prev_gt[g]  = w_gt[g-1];
            assign w_prev_key[g] = r_keys[g-1];
        end
        if (g == DEPTH - 1) begin : g_last
            assign w_next_key[g] = r_keys[g];
        end else begin : g_inner
            assign w_next_key[g] = r_keys[g+1];
        end
    end

    assign w_full   = (r_count == CNT_W'(DEPTH));
    assign w_empty  = (r_count == '0);
    assign w_do_ins = (r_cmd == CMD_INSERT) && !w_full;
    assign w_do_rem = (r_cmd == CMD_REMOVE) && !w_empty;

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            n_keys[i] = r_keys[i];
            if (w_do_ins) begin
                if (w_prev_gt[i]) begin
                    n_keys[i] = w_prev_key[i];
                end else if (w_gt[i] || !w_valid[i]) begin
                    n_keys[i] = r_key;
                end
            end else if (w_do_rem) begin
                n_keys[i] = w_next_key[i];
            end
        end
    end

    always_comb begin
        n_count  = r_count;
        n_status = ST_OK;
        if (w_do_ins) begin
            n_count = r_count + CNT_W'(1);
        end else if (w_do_rem) begin
            n_count = r_count - CNT_W'(1);
        end
        if ((r_cmd == CMD_INSERT) && w_full) begin
            n_status = ST_OVERFLOW;
        end else if ((r_cmd == CMD_REMOVE) && w_empty) begin
            n_status = ST_UNDERFLOW;
        end
        n_front = (n_count != '0) ? FRONT_W'(n_keys[0]) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.execute) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_cmd <= i_command;
            r_key <= KEY_WIDTH'(i_key);
        end
        if (i_cmd.execute) begin
            for (int i = 0; i < DEPTH; i++) begin
                r_keys[i] <= n_keys[i];
            end
            r_front  <= n_front;
            r_ecount <= ECOUNT_W'(n_count);
            r_empty  <= (n_count == '0);
            r_full   <= (n_count == CNT_W'(DEPTH));
            r_status <= n_status;
        end
    end

    assign o_stat.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid     = r_out_valid;
    assign o_front_key     = r_front;
    assign o_entry_count   = r_ecount;
    assign o_empty_flag    = r_empty;
    assign o_full_flag     = r_full;
    assign o_status        = r_status;

endmodule

>>> design/sorted_priority_queue.sv
// Sorted priority queue: top level joining the sequencer and the key-cell datapath.
//
// Holds up to DEPTH keys of KEY_WIDTH bits in ascending order in a row of
// compare-and-shift cells. Each slave transfer carries one command: insert
// (key goes after every stored key that is less than or equal to it) or
// remove (smallest key dropped). Every command yields exactly one master
// transfer with the smallest key after the command (0 when empty), the
// count, the empty and full flags and a status: ok, underflow on a remove
// from an empty queue (no change), or overflow on an insert into a full
// queue (key dropped). A command has a capture step and an execute step
// in which all cells compare against the key in parallel and shift by one
// place. The sequencer holds the execute step while the previous result
// still waits in the output register, and takes no new command until the
// current one has executed. The next command is accepted while a finished
// result waits. Key cells have no reset and no clearing pass; only slots
// below the count are used.
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH     = SPQ_DEPTH,
    parameter int KEY_WIDTH = SPQ_KEY_WIDTH
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [15:0] key
    input  logic                  s_axis_tuser,   // [0] command (0 insert, 1 remove)
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [15:0] front_key, [20:16] entry_count,
                                                  // [21] empty_flag, [22] full_flag, [23] zero
    output logic [STATUS_W-1:0]   m_axis_tuser    // [1:0] status
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;

    logic [FRONT_W-1:0]  w_front_key;
    logic [ECOUNT_W-1:0] w_entry_count;
    logic                w_empty_flag;
    logic                w_full_flag;

    spq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .i_stat     (w_stat),
        .o_in_ready (s_axis_tready),
        .o_cmd      (w_cmd)
    );

    spq_datapath #(
        .DEPTH     (DEPTH),
        .KEY_WIDTH (KEY_WIDTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_stat        (w_stat),
        .i_command     (s_axis_tuser),
        .i_key         (s_axis_tdata[IN_KEY_W-1:0]),
        .i_out_ready   (m_axis_tready),
        .o_out_valid   (m_axis_tvalid),
        .o_front_key   (w_front_key),
        .o_entry_count (w_entry_count),
        .o_empty_flag  (w_empty_flag),
        .o_full_flag   (w_full_flag),
        .o_status      (m_axis_tuser)
    );

    // result fields packed from bit 0 up, padded to whole bytes
    assign m_axis_tdata = {1'b0, w_full_flag, w_empty_flag, w_entry_count, w_front_key};

endmodule

>>> design/spq_checker.sv
// Port-level checks for the sorted priority queue, bound to the top level.
module spq_checker
    import spq_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  s_axis_tvalid,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic [STATUS_W-1:0]   m_axis_tuser
);

    // held result stays put
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // one command in flight: no transfer right after a transfer
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input ready right after a transfer");

    // underflow leaves the queue empty with front key zero
    a_underflow_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_UNDERFLOW) |->
            m_axis_tdata[21] && (m_axis_tdata[20:16] == 5'd0) && (m_axis_tdata[15:0] == 16'd0))
        else $error("underflow reported on a non-empty queue");

    // overflow only on a full queue
    a_overflow_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tuser == ST_OVERFLOW) |-> m_axis_tdata[22] && !m_axis_tdata[21])
        else $error("overflow reported on a queue that is not full");

endmodule

bind sorted_priority_queue spq_checker u_spq_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
